@@ hdl/sev_pkg.sv @@
// sev_pkg: widths, item and result types and arithmetic helpers for the
// symmetric 2x2 eigen pipeline. Used by every module under hdl/.
// No dependencies.
`default_nettype none
package sev_pkg;

	localparam int IN_W     = 32;                // matrix entries, eigenvalue outputs
	localparam int AD_W     = IN_W + 1;          // |hxx-hyy| and 2|hxy|
	localparam int RAD_W    = 70;                // radicands: disc^2 and squared length
	localparam int ROOT_W   = RAD_W / 2;         // root bits, one per sqrt step
	localparam int REM_W    = ROOT_W + 3;        // sqrt partial remainder
	localparam int LAM_W    = IN_W + 2;          // unsaturated eigenvalues
	localparam int SUM_W    = LAM_W + 1;         // trace +/- disc
	localparam int VEC_W    = LAM_W + 1;         // candidate vector components
	localparam int DIR_W    = 16;                // Q1.15 direction components
	localparam int DIR_FRAC = DIR_W - 1;
	localparam int NUM_W    = VEC_W + DIR_FRAC;  // divider dividend

	localparam logic [DIR_W-1:0] DIR_MAX_POS = DIR_W'(32767);
	localparam logic [DIR_W-1:0] DIR_MAG_NEG = DIR_W'(32768);

	localparam logic signed [LAM_W-1:0] LAM_SAT_HI = LAM_W'(64'sd2147483647);
	localparam logic signed [LAM_W-1:0] LAM_SAT_LO = LAM_W'(-64'sd2147483648);

	// One in-flight item; each stage fills the fields it owns.
	typedef struct packed {
		logic signed [IN_W-1:0]  a;
		logic signed [IN_W-1:0]  b;
		logic signed [IN_W-1:0]  c;
		logic [AD_W-1:0]         ad;
		logic [AD_W-1:0]         b2;
		logic [RAD_W-1:0]        rad;
		logic [RAD_W-1:0]        alt;
		logic [ROOT_W-1:0]       root;
		logic signed [LAM_W-1:0] maj;
		logic signed [LAM_W-1:0] mnr;
		logic signed [VEC_W-1:0] vx;
		logic signed [VEC_W-1:0] vy;
		logic [NUM_W-1:0]        rx;
		logic [NUM_W-1:0]        ry;
		logic [DIR_W-1:0]        qx;
		logic [DIR_W-1:0]        qy;
		logic                    degen;
	} item_t;

	typedef struct packed {
		logic signed [IN_W-1:0]  lambda_major;
		logic signed [IN_W-1:0]  lambda_minor;
		logic signed [DIR_W-1:0] dir_x;
		logic signed [DIR_W-1:0] dir_y;
		logic                    degenerate;
	} res_t;

	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sq_t;

	// One digit of the restoring square root: bring down two radicand bits.
	function automatic sq_t sqrt_step(input logic [REM_W-1:0] rem,
			input logic [ROOT_W-1:0] root, input logic [1:0] pair);
		logic [REM_W-1:0] cur;
		logic [REM_W-1:0] trial;
		sq_t r;
		cur   = {rem[REM_W-3:0], pair};
		trial = REM_W'({root, 2'b01});
		if (cur >= trial) begin
			r.rem  = cur - trial;
			r.root = {root[ROOT_W-2:0], 1'b1};
		end else begin
			r.rem  = cur;
			r.root = {root[ROOT_W-2:0], 1'b0};
		end
		return r;
	endfunction

	function automatic logic signed [IN_W-1:0] sat_lam(input logic signed [LAM_W-1:0] x);
		logic signed [LAM_W-1:0] y;
		y = x;
		if (x > LAM_SAT_HI) y = LAM_SAT_HI;
		if (x < LAM_SAT_LO) y = LAM_SAT_LO;
		return IN_W'(y);
	endfunction

	// Signed Q1.15 component from quotient magnitude and sign.
	function automatic logic signed [DIR_W-1:0] dir_sat(input logic neg,
			input logic [DIR_W-1:0] q);
		logic [DIR_W-1:0] m;
		if (neg) begin
			m = (q > DIR_MAG_NEG) ? DIR_MAG_NEG : q;
			return $signed(DIR_W'(-m));
		end
		m = (q > DIR_MAX_POS) ? DIR_MAX_POS : q;
		return $signed(m);
	endfunction

endpackage
`default_nettype wire

@@ hdl/sev_isqrt.sv @@
// sev_isqrt: fully pipelined integer square root, one result bit per stage.
// Takes the radicand from item.rad, returns floor(sqrt) in item.root.
// Depends on sev_pkg.
`default_nettype none
module sev_isqrt (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  sev_pkg::item_t in_item,
	output logic           out_valid,
	output sev_pkg::item_t out_item
);

	logic                         vld_s  [sev_pkg::ROOT_W];
	sev_pkg::item_t               itm_s  [sev_pkg::ROOT_W];
	logic [sev_pkg::REM_W-1:0]    rem_s  [sev_pkg::ROOT_W];
	logic [sev_pkg::ROOT_W-1:0]   root_s [sev_pkg::ROOT_W];

	for (genvar k = 0; k < sev_pkg::ROOT_W; k++) begin : g_step
		logic                       v_src;
		sev_pkg::item_t             i_src;
		logic [sev_pkg::REM_W-1:0]  r_src;
		logic [sev_pkg::ROOT_W-1:0] t_src;
		sev_pkg::sq_t               nxt;

		if (k == 0) begin : g_first
			assign v_src = in_valid;
			assign i_src = in_item;
			assign r_src = '0;
			assign t_src = '0;
		end else begin : g_next
			assign v_src = vld_s[k-1];
			assign i_src = itm_s[k-1];
			assign r_src = rem_s[k-1];
			assign t_src = root_s[k-1];
		end

		assign nxt = sev_pkg::sqrt_step(r_src, t_src,
			i_src.rad[sev_pkg::RAD_W-1-2*k -: 2]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[k] <= 1'b0;
			else if (en) vld_s[k] <= v_src;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				itm_s[k]  <= i_src;
				rem_s[k]  <= nxt.rem;
				root_s[k] <= nxt.root;
			end
		end
	end

	assign out_valid = vld_s[sev_pkg::ROOT_W-1];

	always_comb begin
		out_item      = itm_s[sev_pkg::ROOT_W-1];
		out_item.root = root_s[sev_pkg::ROOT_W-1];
	end

endmodule
`default_nettype wire

@@ hdl/sev_div.sv @@
// sev_div: pipelined restoring divider, one quotient bit per stage, for both
// direction components at once: q = |v| * 2^15 / norm. Depends on sev_pkg.
`default_nettype none
module sev_div (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  sev_pkg::item_t in_item,
	output logic           out_valid,
	output sev_pkg::item_t out_item
);

	logic           vld_s [sev_pkg::DIR_W];
	sev_pkg::item_t itm_s [sev_pkg::DIR_W];

	logic [sev_pkg::VEC_W-1:0] mag_x, mag_y;
	sev_pkg::item_t            init;

	// Seed the dividends with the magnitudes scaled by 2^15.
	always_comb begin
		mag_x = in_item.vx[sev_pkg::VEC_W-1] ? sev_pkg::VEC_W'(-in_item.vx)
			: sev_pkg::VEC_W'(in_item.vx);
		mag_y = in_item.vy[sev_pkg::VEC_W-1] ? sev_pkg::VEC_W'(-in_item.vy)
			: sev_pkg::VEC_W'(in_item.vy);
		init    = in_item;
		init.rx = {mag_x, sev_pkg::DIR_FRAC'(0)};
		init.ry = {mag_y, sev_pkg::DIR_FRAC'(0)};
		init.qx = '0;
		init.qy = '0;
	end

	for (genvar k = 0; k < sev_pkg::DIR_W; k++) begin : g_step
		localparam int B = sev_pkg::DIR_W - 1 - k;
		logic                      v_src;
		sev_pkg::item_t            i_src;
		sev_pkg::item_t            nxt;
		logic [sev_pkg::NUM_W-1:0] dvs;

		if (k == 0) begin : g_first
			assign v_src = in_valid;
			assign i_src = init;
		end else begin : g_next
			assign v_src = vld_s[k-1];
			assign i_src = itm_s[k-1];
		end

		always_comb begin
			dvs = sev_pkg::NUM_W'(i_src.root) << B;
			nxt = i_src;
			if (i_src.rx >= dvs) begin
				nxt.rx    = i_src.rx - dvs;
				nxt.qx[B] = 1'b1;
			end
			if (i_src.ry >= dvs) begin
				nxt.ry    = i_src.ry - dvs;
				nxt.qy[B] = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[k] <= 1'b0;
			else if (en) vld_s[k] <= v_src;
		end

		always_ff @(posedge clk) begin
			if (en) itm_s[k] <= nxt;
		end
	end

	assign out_valid = vld_s[sev_pkg::DIR_W-1];
	assign out_item  = itm_s[sev_pkg::DIR_W-1];

endmodule
`default_nettype wire

@@ hdl/sev_obuf.sv @@
// sev_obuf: output register plus one skid entry at the pipeline tail.
// Holds the whole pipeline only while the skid entry is occupied. Depends on sev_pkg.
`default_nettype none
module sev_obuf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          p_valid,
	input  sev_pkg::res_t p_data,
	output logic          pipe_en,
	output logic          out_valid,
	input  logic          out_stall,
	output sev_pkg::res_t out_data
);

	logic          out_v_q, skid_v_q;
	sev_pkg::res_t out_q, skid_q;
	logic          take;

	assign take    = out_v_q && !out_stall;
	assign pipe_en = !skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (take) skid_v_q <= 1'b0;
		end else if (p_valid) begin
			if (!out_v_q || take) out_v_q <= 1'b1;
			else skid_v_q <= 1'b1;
		end else if (take) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (take) out_q <= skid_q;
		end else if (p_valid) begin
			if (!out_v_q || take) out_q <= p_data;
			else skid_q <= p_data;
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = out_q;

`ifndef ASSERT_OFF
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q) else $error("skid entry held with empty output register");
	a_skid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q && out_stall |=> skid_v_q && $stable(skid_q))
		else $error("skid entry lost while output stalled");
	a_park_in_skid: assert property (@(posedge clk) disable iff (!arst_n)
		p_valid && !skid_v_q && out_v_q && out_stall |=> skid_v_q)
		else $error("tail beat dropped instead of parked");
	a_degen_dir: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && out_q.degenerate |->
		out_q.dir_x == $signed(sev_pkg::DIR_MAX_POS) && out_q.dir_y == '0)
		else $error("degenerate beat without (1,0) direction");
`endif

endmodule
`default_nettype wire

@@ hdl/symmetric_2x2_eigen.sv @@
// symmetric_2x2_eigen: top level of the closed-form 2x2 symmetric eigen pipeline.
// Depends on sev_pkg, sev_isqrt, sev_div and sev_obuf.
//
// Takes one Hessian [hxx hxy; hxy hyy] (signed Q16.16) per beat and returns
// one beat with both eigenvalues (larger magnitude first, saturated Q16.16),
// the unit eigenvector of the major eigenvalue in Q1.15 and a degenerate
// flag. A new beat is accepted every clock while in_stall is low. Stages: input
// register, one squaring stage, a 35-stage square root for the discriminant,
// four stages for eigenvalues and candidate vectors, a second 35-stage square
// root for the vector norm, a 16-stage divider for both components and the
// output register. in_stall rises only when the output side has stalled long
// enough to fill the single skid entry behind the output register; the whole
// pipeline then holds until that entry drains. degenerate_threshold (Q32.32
// squared length) is written through cfg_wr_en/cfg_wr_data, resets to 0 and
// must only change while no beats are in flight.
`default_nettype none
module symmetric_2x2_eigen (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [31:0]                          cfg_wr_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [sev_pkg::IN_W-1:0]      hxx,
	input  logic signed [sev_pkg::IN_W-1:0]      hxy,
	input  logic signed [sev_pkg::IN_W-1:0]      hyy,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [sev_pkg::IN_W-1:0]      lambda_major,
	output logic signed [sev_pkg::IN_W-1:0]      lambda_minor,
	output logic signed [sev_pkg::DIR_W-1:0]     dir_x,
	output logic signed [sev_pkg::DIR_W-1:0]     dir_y,
	output logic                                 degenerate
);

	// Threshold register; the user must write it only while the pipeline is empty, the block does not enforce this.
	logic [31:0] thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) thr_q <= '0;
		else if (cfg_wr_en) thr_q <= cfg_wr_data;
	end

	// One enable for every stage: advance unless the skid entry is full.
	logic pipe_en;
	assign in_stall = !pipe_en;

	// Stage 1: register the beat with |hxx-hyy| and 2|hxy|.
	logic                           vld_s1;
	sev_pkg::item_t                 itm_s1;
	sev_pkg::item_t                 itm_in;
	logic signed [sev_pkg::AD_W-1:0] diff_in;
	logic [sev_pkg::IN_W-1:0]       mb_in;

	always_comb begin
		diff_in       = sev_pkg::AD_W'(hxx) - sev_pkg::AD_W'(hyy);
		mb_in         = hxy[sev_pkg::IN_W-1] ? sev_pkg::IN_W'(-hxy) : sev_pkg::IN_W'(hxy);
		itm_in        = '0;
		itm_in.a      = hxx;
		itm_in.b      = hxy;
		itm_in.c      = hyy;
		itm_in.ad     = diff_in[sev_pkg::AD_W-1] ? sev_pkg::AD_W'(-diff_in)
			: sev_pkg::AD_W'(diff_in);
		itm_in.b2     = {mb_in, 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (pipe_en) vld_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (pipe_en) itm_s1 <= itm_in;
	end

	// Stage 2: disc^2 = (hxx-hyy)^2 + (2 hxy)^2.
	logic                              vld_s2;
	sev_pkg::item_t                    itm_s2;
	logic [2*sev_pkg::AD_W-1:0]        sq_d, sq_b;

	always_comb begin
		sq_d = itm_s1.ad * itm_s1.ad;
		sq_b = itm_s1.b2 * itm_s1.b2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (pipe_en) vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			itm_s2     <= itm_s1;
			itm_s2.rad <= sev_pkg::RAD_W'(sq_d) + sev_pkg::RAD_W'(sq_b);
		end
	end

	// Discriminant root.
	logic           vld_a;
	sev_pkg::item_t itm_a;

	sev_isqrt u_disc (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (pipe_en),
		.in_valid  (vld_s2),
		.in_item   (itm_s2),
		.out_valid (vld_a),
		.out_item  (itm_a)
	);

	// Stage 3: eigenvalues (trace +/- disc) >>> 1, order by magnitude.
	logic                               vld_s3;
	sev_pkg::item_t                     itm_s3;
	logic signed [sev_pkg::SUM_W-1:0]   disc_w, tr_w, sum_p, sum_m;
	logic signed [sev_pkg::LAM_W-1:0]   mu1, mu2;
	logic [sev_pkg::LAM_W-1:0]          mag1, mag2;

	always_comb begin
		disc_w = $signed({1'b0, itm_a.root[sev_pkg::LAM_W-1:0]});
		tr_w   = sev_pkg::SUM_W'(itm_a.a) + sev_pkg::SUM_W'(itm_a.c);
		sum_p  = tr_w + disc_w;
		sum_m  = tr_w - disc_w;
		mu1    = sev_pkg::LAM_W'(sum_p >>> 1);
		mu2    = sev_pkg::LAM_W'(sum_m >>> 1);
		mag1   = mu1[sev_pkg::LAM_W-1] ? sev_pkg::LAM_W'(-mu1) : sev_pkg::LAM_W'(mu1);
		mag2   = mu2[sev_pkg::LAM_W-1] ? sev_pkg::LAM_W'(-mu2) : sev_pkg::LAM_W'(mu2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (pipe_en) vld_s3 <= vld_a;
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			itm_s3 <= itm_a;
			// Ties keep the (trace + disc) root as major.
			if (mag1 >= mag2) begin
				itm_s3.maj <= mu1;
				itm_s3.mnr <= mu2;
			end else begin
				itm_s3.maj <= mu2;
				itm_s3.mnr <= mu1;
			end
		end
	end

	// Stage 4: candidate components L-hxx (into vy) and L-hyy (into vx).
	logic           vld_s4;
	sev_pkg::item_t itm_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else if (pipe_en) vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			itm_s4    <= itm_s3;
			itm_s4.vy <= sev_pkg::VEC_W'(itm_s3.maj) - sev_pkg::VEC_W'(itm_s3.a);
			itm_s4.vx <= sev_pkg::VEC_W'(itm_s3.maj) - sev_pkg::VEC_W'(itm_s3.c);
		end
	end

	// Stage 5: squared lengths of both candidates.
	logic                          vld_s5;
	sev_pkg::item_t                itm_s5;
	logic [sev_pkg::IN_W-1:0]      mb4;
	logic [sev_pkg::VEC_W-1:0]     m1, m2;
	logic [2*sev_pkg::IN_W-1:0]    sq_bb;
	logic [2*sev_pkg::VEC_W-1:0]   sq_1, sq_2;

	always_comb begin
		mb4   = itm_s4.b[sev_pkg::IN_W-1] ? sev_pkg::IN_W'(-itm_s4.b)
			: sev_pkg::IN_W'(itm_s4.b);
		m1    = itm_s4.vy[sev_pkg::VEC_W-1] ? sev_pkg::VEC_W'(-itm_s4.vy)
			: sev_pkg::VEC_W'(itm_s4.vy);
		m2    = itm_s4.vx[sev_pkg::VEC_W-1] ? sev_pkg::VEC_W'(-itm_s4.vx)
			: sev_pkg::VEC_W'(itm_s4.vx);
		sq_bb = mb4 * mb4;
		sq_1  = m1 * m1;
		sq_2  = m2 * m2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else if (pipe_en) vld_s5 <= vld_s4;
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			itm_s5     <= itm_s4;
			itm_s5.rad <= sev_pkg::RAD_W'(sq_bb) + sev_pkg::RAD_W'(sq_1);
			itm_s5.alt <= sev_pkg::RAD_W'(sq_bb) + sev_pkg::RAD_W'(sq_2);
		end
	end

	// Stage 6: pick the longer candidate (first on a tie), test threshold.
	logic           vld_s6;
	sev_pkg::item_t itm_s6;
	sev_pkg::item_t pick;

	always_comb begin
		pick = itm_s5;
		if (itm_s5.alt <= itm_s5.rad) begin
			pick.vx = sev_pkg::VEC_W'(itm_s5.b);
		end else begin
			pick.vy  = sev_pkg::VEC_W'(itm_s5.b);
			pick.rad = itm_s5.alt;
		end
		pick.degen = pick.rad <= sev_pkg::RAD_W'(thr_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s6 <= 1'b0;
		else if (pipe_en) vld_s6 <= vld_s5;
	end

	always_ff @(posedge clk) begin
		if (pipe_en) itm_s6 <= pick;
	end

	// Vector norm.
	logic           vld_b;
	sev_pkg::item_t itm_b;

	sev_isqrt u_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (pipe_en),
		.in_valid  (vld_s6),
		.in_item   (itm_s6),
		.out_valid (vld_b),
		.out_item  (itm_b)
	);

	// Normalize both components.
	logic           vld_c;
	sev_pkg::item_t itm_c;

	sev_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (pipe_en),
		.in_valid  (vld_b),
		.in_item   (itm_b),
		.out_valid (vld_c),
		.out_item  (itm_c)
	);

	// Saturate and format; degenerate beats fall back to (1,0).
	sev_pkg::res_t res_c, res_out;

	always_comb begin
		res_c.lambda_major = sev_pkg::sat_lam(itm_c.maj);
		res_c.lambda_minor = sev_pkg::sat_lam(itm_c.mnr);
		res_c.degenerate   = itm_c.degen;
		if (itm_c.degen) begin
			res_c.dir_x = $signed(sev_pkg::DIR_MAX_POS);
			res_c.dir_y = '0;
		end else begin
			res_c.dir_x = sev_pkg::dir_sat(itm_c.vx[sev_pkg::VEC_W-1], itm_c.qx);
			res_c.dir_y = sev_pkg::dir_sat(itm_c.vy[sev_pkg::VEC_W-1], itm_c.qy);
		end
	end

	sev_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.p_valid   (vld_c),
		.p_data    (res_c),
		.pipe_en   (pipe_en),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (res_out)
	);

	assign lambda_major = res_out.lambda_major;
	assign lambda_minor = res_out.lambda_minor;
	assign dir_x        = res_out.dir_x;
	assign dir_y        = res_out.dir_y;
	assign degenerate   = res_out.degenerate;

endmodule
`default_nettype wire
